>>> design/tvsg_pkg.sv
`timescale 1ns / 1ps
// tvsg_pkg: shared types, register map codes and small helper functions
// of the three voice sound generator; no dependencies
package tvsg_pkg;

    // request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // register map
    localparam int         NUM_REGS       = 16;
    localparam logic [3:0] REG_NOISE_PER  = 4'd6;
    localparam logic [3:0] REG_ENABLE     = 4'd7;
    localparam logic [3:0] REG_ENV_FINE   = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE  = 4'd13;
    localparam logic [3:0] REG_PORT_A     = 4'd14;
    localparam logic [3:0] REG_PORT_B     = 4'd15;
    localparam int         VOL_BASE       = 8;
    localparam int         ENABLE_PA_BIT  = 6;
    localparam int         ENABLE_PB_BIT  = 7;
    localparam logic [7:0] ENABLE_RESET   = 8'h80;

    // configuration register indexes (APB word address)
    localparam logic CFG_IS_AY     = 1'b0;
    localparam logic CFG_FORCE_DIR = 1'b1;

    localparam int TONE_W  = 12;
    localparam int NOISE_W = 6;
    localparam int LFSR_W  = 17;
    localparam int ENV_W   = 17;
    localparam int LEVEL_W = 5;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] port_a_pins;
        logic [7:0] port_b_pins;
    } t_req;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_a;
        logic [LEVEL_W-1:0] level_b;
        logic [LEVEL_W-1:0] level_c;
        logic [7:0]         read_data;
        logic [7:0]         port_a_drive;
        logic [7:0]         port_b_drive;
    } t_res;

    // envelope control from the register side
    typedef struct packed {
        logic             tick;
        logic             shape_wr;
        logic [3:0]       shape;
        logic             clip;
        logic [ENV_W-1:0] period;
    } t_env_ctl;

    // envelope level before and after the current word
    typedef struct packed {
        logic [LEVEL_W-1:0] cur_e;
        logic [LEVEL_W-1:0] nxt_e;
    } t_env_lvl;

    // read mask applied in the AY variant
    function automatic logic [7:0] read_mask(input logic [3:0] idx);
        logic [7:0] m;
        case (idx) inside
            4'd1, 4'd3, 4'd5, 4'd13: m = 8'h0F;
            4'd6, 4'd8, 4'd9, 4'd10: m = 8'h1F;
            default:                 m = 8'hFF;
        endcase
        return m;
    endfunction

    function automatic logic [TONE_W-1:0] tone_period(input logic [7:0] fine,
                                                      input logic [7:0] coarse);
        logic [TONE_W-1:0] p;
        p = {coarse[3:0], fine};
        return (p == '0) ? TONE_W'(1) : p;
    endfunction

    function automatic logic [NOISE_W-1:0] noise_period(input logic [7:0] r);
        logic [4:0] v;
        v = r[4:0];
        return (v == '0) ? NOISE_W'(2) : {v, 1'b0};
    endfunction

    function automatic logic [ENV_W-1:0] env_period(input logic [7:0] fine,
                                                    input logic [7:0] coarse);
        logic [15:0] v;
        v = {coarse, fine};
        return (v == '0) ? ENV_W'(1) : {v, 1'b0};
    endfunction

    // level code from a volume register and the envelope value
    function automatic logic [LEVEL_W-1:0] level_code(input logic [7:0] vol,
                                                      input logic [LEVEL_W-1:0] e,
                                                      input logic ay);
        logic [LEVEL_W-1:0] c;
        if (vol[4]) begin
            if (ay) begin
                c = (e < LEVEL_W'(2)) ? '0 : (e | LEVEL_W'(1));
            end else begin
                c = e;
            end
        end else begin
            c = (vol[3:0] == '0) ? '0 : {vol[3:0], 1'b1};
        end
        return c;
    endfunction

endpackage

>>> design/tvsg_if.sv
`timescale 1ns / 1ps
// tvsg_req_if, tvsg_res_if: valid/ready channels for requests and results
// depends on tvsg_pkg for the payload structs
interface tvsg_req_if import tvsg_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tvsg_res_if import tvsg_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/tvsg_env.sv
`timescale 1ns / 1ps
// tvsg_env: envelope divider and 32-step shape generator
// depends on tvsg_pkg
module tvsg_env import tvsg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_env_ctl i_ctl,
    output t_env_lvl o_lvl
);

    logic [ENV_W-1:0]   r_count, n_count;
    logic [LEVEL_W-1:0] r_step, n_step;
    logic               r_attack, n_attack;
    logic               r_hold, n_hold;
    logic               r_alt, n_alt;
    logic               r_holding, n_holding;

    logic [ENV_W:0]     count_inc;
    logic [LEVEL_W:0]   step_diff;

    // shape restart, period clip, divider and step update
    always_comb begin
        n_count   = r_count;
        n_step    = r_step;
        n_attack  = r_attack;
        n_hold    = r_hold;
        n_alt     = r_alt;
        n_holding = r_holding;
        count_inc = {1'b0, r_count} + (ENV_W+1)'(2);
        step_diff = {1'b0, r_step} - ((i_ctl.period == ENV_W'(1)) ? (LEVEL_W+1)'(2)
                                                                 : (LEVEL_W+1)'(1));
        if (i_ctl.shape_wr) begin
            n_attack = i_ctl.shape[2];
            if (!i_ctl.shape[3]) begin
                n_hold = 1'b1;
                n_alt  = i_ctl.shape[2];
            end else begin
                n_hold = i_ctl.shape[0];
                n_alt  = i_ctl.shape[1];
            end
            n_count   = '0;
            n_step    = '1;
            n_holding = 1'b0;
        end else if (i_ctl.clip) begin
            if (r_count > i_ctl.period - ENV_W'(1)) begin
                n_count = i_ctl.period - ENV_W'(1);
            end
        end else if (i_ctl.tick && !r_holding) begin
            if (count_inc >= {1'b0, i_ctl.period}) begin
                n_count = '0;
                if (step_diff[LEVEL_W]) begin
                    // wrapped below zero
                    if (r_hold) begin
                        if (r_alt) begin
                            n_attack = ~r_attack;
                        end
                        n_holding = 1'b1;
                        n_step    = '0;
                    end else begin
                        if (r_alt && step_diff[LEVEL_W-1]) begin
                            n_attack = ~r_attack;
                        end
                        n_step = step_diff[LEVEL_W-1:0];
                    end
                end else begin
                    n_step = step_diff[LEVEL_W-1:0];
                end
            end else begin
                n_count = count_inc[ENV_W-1:0];
            end
        end
    end

    // state registers, reset matches shape zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_step    <= '1;
            r_attack  <= 1'b0;
            r_hold    <= 1'b1;
            r_alt     <= 1'b0;
            r_holding <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_step    <= n_step;
            r_attack  <= n_attack;
            r_hold    <= n_hold;
            r_alt     <= n_alt;
            r_holding <= n_holding;
        end
    end

    assign o_lvl.cur_e = r_step ^ {LEVEL_W{r_attack}};
    assign o_lvl.nxt_e = n_step ^ {LEVEL_W{n_attack}};

endmodule

>>> design/tvsg_skid.sv
`timescale 1ns / 1ps
// tvsg_skid: result register plus one skid entry toward the result channel
// depends on tvsg_pkg and tvsg_res_if
module tvsg_skid import tvsg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_valid,
    input  t_res              i_wr_data,
    output logic              o_wr_ready,
    tvsg_res_if.source        o_res
);

    logic r_out_valid, n_out_valid;
    logic r_skid_valid, n_skid_valid;
    t_res r_out_data, n_out_data;
    t_res r_skid_data, n_skid_data;
    logic out_fire;

    assign out_fire   = r_out_valid && o_res.ready;
    assign o_wr_ready = !r_skid_valid;

    // fill the output register first, park in skid when it is stalled
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_data   = r_out_data;
        n_skid_data  = r_skid_data;
        if (i_wr_valid) begin
            if (!r_out_valid || out_fire) begin
                n_out_valid = 1'b1;
                n_out_data  = i_wr_data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = i_wr_data;
            end
        end else if (out_fire) begin
            if (r_skid_valid) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_data;

endmodule

>>> design/three_voice_sound_generator.sv
`timescale 1ns / 1ps
// three_voice_sound_generator: top level with register file, tone and noise
// dividers and level gating; uses tvsg_pkg, tvsg_if, tvsg_env and tvsg_skid
//
// One request word (tick, register write or register read) is taken per
// clock and gives exactly one result word, which is registered. All state update
// for a word happens in the cycle it is accepted, so words can follow each
// other with no gaps; the result register and one skid entry let a word be
// accepted while a result waits, and i_req.ready drops only when two results
// are waiting. On a tick the levels are those before the tick's update, on a
// write or read those after it. The APB port holds the variant select and
// the port direction rule; change them only while the block is idle.
module three_voice_sound_generator import tvsg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tvsg_req_if.sink    i_req,
    tvsg_res_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                r_ay;
    logic                r_force;
    logic [7:0]          r_regs [NUM_REGS];
    logic [7:0]          n_regs [NUM_REGS];
    logic [TONE_W-1:0]   r_tone_count [3];
    logic [TONE_W-1:0]   n_tone_count [3];
    logic [2:0]          r_tone_out, n_tone_out;
    logic [NOISE_W-1:0]  r_noise_count, n_noise_count;
    logic [LFSR_W-1:0]   r_lfsr, n_lfsr;

    logic                accept;
    logic                is_tick;
    logic                is_wr;
    logic                is_rd;
    logic                addr_ok;
    logic [3:0]          idx;
    logic [7:0]          wval;
    logic [7:0]          rd_val;
    logic [TONE_W-1:0]   tone_p;
    logic [TONE_W:0]     tone_inc;
    logic [NOISE_W-1:0]  noise_p;
    logic [NOISE_W:0]    noise_inc;
    logic [LEVEL_W-1:0]  env_e;
    logic [LEVEL_W-1:0]  lvl [3];
    logic                gate;
    logic                skid_ready;
    t_env_ctl            env_ctl;
    t_env_lvl            env_lvl;
    t_res                res;

    assign accept      = i_req.valid && skid_ready;
    assign i_req.ready = skid_ready;
    assign is_tick     = accept && (i_req.data.req_type == REQ_TICK);
    assign is_wr       = accept && (i_req.data.req_type == REQ_WRITE);
    assign is_rd       = accept && (i_req.data.req_type == REQ_READ);
    assign addr_ok     = (i_req.data.reg_addr[7:4] == 4'd0);
    assign idx         = i_req.data.reg_addr[3:0];

    // configuration port
    assign pready = 1'b1;
    assign prdata = {31'd0, (paddr[2] == CFG_FORCE_DIR) ? r_force : r_ay};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ay    <= 1'b1;
            r_force <= 1'b1;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == CFG_IS_AY) begin
                r_ay <= pwdata[0];
            end else begin
                r_force <= pwdata[0];
            end
        end
    end

    // register file writes, input port capture and read data
    always_comb begin
        n_regs = r_regs;
        wval   = i_req.data.write_data;
        if (idx == REG_ENABLE && r_force) begin
            wval[ENABLE_PA_BIT] = 1'b0;
            wval[ENABLE_PB_BIT] = 1'b1;
        end
        if (is_wr && addr_ok) begin
            n_regs[idx] = wval;
        end
        if (is_rd && addr_ok) begin
            if (idx == REG_PORT_A && !r_regs[REG_ENABLE][ENABLE_PA_BIT]) begin
                n_regs[REG_PORT_A] = i_req.data.port_a_pins;
            end
            if (idx == REG_PORT_B && !r_regs[REG_ENABLE][ENABLE_PB_BIT]) begin
                n_regs[REG_PORT_B] = i_req.data.port_b_pins;
            end
        end
        rd_val = 8'd0;
        if (i_req.data.req_type == REQ_READ) begin
            if (addr_ok) begin
                rd_val = n_regs[idx] & (r_ay ? read_mask(idx) : 8'hFF);
            end else begin
                rd_val = 8'hFF;
            end
        end
    end

    // tone dividers: count on tick, clip on period write
    always_comb begin
        n_tone_out = r_tone_out;
        tone_p     = '0;
        tone_inc   = '0;
        for (int ch = 0; ch < 3; ch++) begin
            n_tone_count[ch] = r_tone_count[ch];
            tone_p   = tone_period(n_regs[2*ch], n_regs[2*ch+1]);
            tone_inc = {1'b0, r_tone_count[ch]} + (TONE_W+1)'(1);
            if (is_tick) begin
                if (tone_inc >= {1'b0, tone_p}) begin
                    n_tone_count[ch] = '0;
                    n_tone_out[ch]   = ~r_tone_out[ch];
                end else begin
                    n_tone_count[ch] = tone_inc[TONE_W-1:0];
                end
            end else if (is_wr && addr_ok && idx < REG_NOISE_PER && idx[2:1] == 2'(ch)) begin
                if (r_tone_count[ch] > tone_p - TONE_W'(1)) begin
                    n_tone_count[ch] = tone_p - TONE_W'(1);
                end
            end
        end
    end

    // noise divider and lfsr
    always_comb begin
        n_noise_count = r_noise_count;
        n_lfsr        = r_lfsr;
        noise_p       = noise_period(n_regs[REG_NOISE_PER]);
        noise_inc     = {1'b0, r_noise_count} + (NOISE_W+1)'(1);
        if (is_tick) begin
            if (noise_inc >= {1'b0, noise_p}) begin
                n_noise_count = '0;
                n_lfsr        = {1'b0, r_lfsr[LFSR_W-1:1]};
                n_lfsr[13]    = n_lfsr[13] ^ r_lfsr[0];
                n_lfsr[16]    = n_lfsr[16] ^ r_lfsr[0];
            end else begin
                n_noise_count = noise_inc[NOISE_W-1:0];
            end
        end else if (is_wr && addr_ok && idx == REG_NOISE_PER) begin
            if (r_noise_count > noise_p - NOISE_W'(1)) begin
                n_noise_count = noise_p - NOISE_W'(1);
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= (4'(i) == REG_ENABLE) ? ENABLE_RESET : 8'd0;
            end
            for (int ch = 0; ch < 3; ch++) begin
                r_tone_count[ch] <= '0;
            end
            r_tone_out    <= '0;
            r_noise_count <= '0;
            r_lfsr        <= LFSR_W'(1);
        end else begin
            r_regs        <= n_regs;
            r_tone_count  <= n_tone_count;
            r_tone_out    <= n_tone_out;
            r_noise_count <= n_noise_count;
            r_lfsr        <= n_lfsr;
        end
    end

    // envelope
    always_comb begin
        env_ctl.tick     = is_tick;
        env_ctl.shape_wr = is_wr && addr_ok && idx == REG_ENV_SHAPE;
        env_ctl.shape    = i_req.data.write_data[3:0];
        env_ctl.clip     = is_wr && addr_ok &&
                           (idx == REG_ENV_FINE || idx == REG_ENV_COARSE);
        env_ctl.period   = env_period(n_regs[REG_ENV_FINE], n_regs[REG_ENV_COARSE]);
    end

    tvsg_env u_env (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (env_ctl),
        .o_lvl   (env_lvl)
    );

    // gated levels; ticks show the state held during the tick
    always_comb begin
        env_e = is_tick ? env_lvl.cur_e : env_lvl.nxt_e;
        gate  = 1'b0;
        for (int ch = 0; ch < 3; ch++) begin
            gate = (r_tone_out[ch] | n_regs[REG_ENABLE][ch]) &
                   (r_lfsr[0] | n_regs[REG_ENABLE][ch+3]);
            lvl[ch] = gate ? level_code(n_regs[VOL_BASE+ch], env_e, r_ay) : '0;
        end
    end

    // result word
    always_comb begin
        res.level_a      = lvl[0];
        res.level_b      = lvl[1];
        res.level_c      = lvl[2];
        res.read_data    = rd_val;
        res.port_a_drive = n_regs[REG_ENABLE][ENABLE_PA_BIT] ? n_regs[REG_PORT_A] : 8'hFF;
        res.port_b_drive = n_regs[REG_ENABLE][ENABLE_PB_BIT] ? n_regs[REG_PORT_B] : 8'hFF;
    end

    tvsg_skid u_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (accept),
        .i_wr_data  (res),
        .o_wr_ready (skid_ready),
        .o_res      (o_res)
    );

endmodule

>>> tb/tb_three_voice_sound_generator.sv
`timescale 1ns / 1ps
// tb_three_voice_sound_generator: self-checking bench for the sound generator
// uses tvsg_pkg, tvsg_req_if/tvsg_res_if and the three_voice_sound_generator top
module tb_three_voice_sound_generator import tvsg_pkg::*; ();

    // codes with no name in the package
    localparam logic [1:0] REQ_NONE          = 2'd3;
    localparam logic [7:0] REG_TONE_A_FINE   = 8'd0;
    localparam logic [7:0] REG_TONE_A_COARSE = 8'd1;

    // per phase: {variant select, port direction rule}
    localparam bit [1:0] PHASE_MODE [4] = '{2'b11, 2'b00, 2'b01, 2'b10};
    localparam int PHASE_WORDS = 362;

    // sound generator state tracker and result checker
    class tvsg_scoreboard;
        bit                  ay_mode;
        bit                  dir_rule;
        bit [7:0]            regs [NUM_REGS];
        bit [TONE_W-1:0]     tone_cnt [3];
        bit                  tone_sq [3];
        bit [NOISE_W-1:0]    noise_cnt;
        bit [LFSR_W-1:0]     lfsr;
        bit [ENV_W-1:0]      env_cnt;
        int                  env_pos;
        bit [LEVEL_W-1:0]    env_flip;
        bit                  env_hold_mode;
        bit                  env_alt_mode;
        bit                  env_frozen;
        t_res                expected_q [$];
        int                  errors;

        function new();
            ay_mode   = 1'b1;
            dir_rule  = 1'b1;
            noise_cnt = '0;
            lfsr      = LFSR_W'(1);
            env_cnt   = '0;
            errors    = 0;
            foreach (regs[i]) regs[i] = '0;
            foreach (tone_cnt[i]) begin
                tone_cnt[i] = '0;
                tone_sq[i]  = 1'b0;
            end
            foreach (regs[i]) store_reg(i, 8'h00);
        endfunction

        function bit [TONE_W-1:0] tone_len(int ch);
            bit [TONE_W-1:0] p;
            p = {regs[2*ch+1][3:0], regs[2*ch]};
            return (p == 0) ? TONE_W'(1) : p;
        endfunction

        function bit [NOISE_W-1:0] noise_len();
            bit [4:0] v;
            v = regs[REG_NOISE_PER][4:0];
            return (v == 0) ? NOISE_W'(2) : {v, 1'b0};
        endfunction

        // envelope period in half ticks
        function bit [ENV_W-1:0] env_len();
            bit [15:0] v;
            v = {regs[REG_ENV_COARSE], regs[REG_ENV_FINE]};
            return (v == 0) ? ENV_W'(1) : {v, 1'b0};
        endfunction

        function void restart_shape(bit [7:0] s);
            env_flip = s[2] ? 5'h1F : 5'h00;
            if (!s[3]) begin
                env_hold_mode = 1'b1;
                env_alt_mode  = (env_flip != 0);
            end else begin
                env_hold_mode = s[0];
                env_alt_mode  = s[1];
            end
            env_cnt    = '0;
            env_pos    = 31;
            env_frozen = 1'b0;
        endfunction

        function void step_env(int n);
            if (env_frozen) return;
            env_pos -= n;
            if (env_pos < 0) begin
                if (env_hold_mode) begin
                    if (env_alt_mode) env_flip ^= 5'h1F;
                    env_frozen = 1'b1;
                    env_pos    = 0;
                end else begin
                    // wrap into the next 32-step cycle
                    if (env_alt_mode && env_pos[4]) env_flip ^= 5'h1F;
                    env_pos = env_pos & 31;
                end
            end
        endfunction

        function void store_reg(int unsigned addr, bit [7:0] v);
            int unsigned ch;
            if (addr >= NUM_REGS) return;
            if (addr == REG_ENABLE && dir_rule) begin
                v[ENABLE_PA_BIT] = 1'b0;
                v[ENABLE_PB_BIT] = 1'b1;
            end
            regs[addr] = v;
            // period writes clip the running count, a shape write restarts the envelope
            if (addr < REG_NOISE_PER) begin
                ch = addr / 2;
                if (tone_cnt[ch] > tone_len(ch) - 1) tone_cnt[ch] = tone_len(ch) - 1;
            end else if (addr == REG_NOISE_PER) begin
                if (noise_cnt > noise_len() - 1) noise_cnt = noise_len() - 1;
            end else if (addr == REG_ENV_FINE || addr == REG_ENV_COARSE) begin
                if (env_cnt > env_len() - 1) env_cnt = env_len() - 1;
            end else if (addr == REG_ENV_SHAPE) begin
                restart_shape(v);
            end
        endfunction

        function bit [7:0] read_bits(int unsigned r);
            if (r < REG_NOISE_PER) return r[0] ? 8'h0F : 8'hFF;
            if (r == REG_ENV_SHAPE) return 8'h0F;
            if (r == REG_NOISE_PER || (r >= VOL_BASE && r < VOL_BASE + 3)) return 8'h1F;
            return 8'hFF;
        endfunction

        function bit [LEVEL_W-1:0] voice_level(int ch);
            bit [7:0]         vr;
            bit [7:0]         en;
            bit [LEVEL_W-1:0] e;
            bit [LEVEL_W-1:0] code;
            bit               gate;
            vr = regs[VOL_BASE + ch];
            en = regs[REG_ENABLE];
            if (vr[4]) begin
                e = env_pos[4:0] ^ env_flip;
                if (ay_mode) code = (e < 2) ? 5'd0 : (e | 5'd1);
                else code = e;
            end else begin
                code = (vr[3:0] == 0) ? 5'd0 : {vr[3:0], 1'b1};
            end
            gate = (tone_sq[ch] | en[ch]) & (lfsr[0] | en[ch + 3]);
            return gate ? code : 5'd0;
        endfunction

        function void advance_tick();
            bit               b;
            bit [ENV_W-1:0]   p;
            for (int ch = 0; ch < 3; ch++) begin
                tone_cnt[ch] += 1;
                if (tone_cnt[ch] >= tone_len(ch)) begin
                    tone_cnt[ch] = '0;
                    tone_sq[ch] ^= 1'b1;
                end
            end
            noise_cnt += 1;
            if (noise_cnt >= noise_len()) begin
                b         = lfsr[0];
                noise_cnt = '0;
                lfsr      = {1'b0, lfsr[LFSR_W-1:1]} ^ ({LFSR_W{b}} & 17'h12000);
            end
            // envelope counter runs in half ticks and stops while holding
            if (!env_frozen) begin
                p = env_len();
                env_cnt += 2;
                if (env_cnt >= p) begin
                    env_cnt = '0;
                    step_env((p == 1) ? 2 : 1);
                end
            end
        endfunction

        function void note_request(t_req w);
            t_res        r;
            int unsigned a;
            r = '0;
            a = w.reg_addr;
            if (w.req_type == REQ_TICK) begin
                // levels held during the tick, then the update
                r.level_a = voice_level(0);
                r.level_b = voice_level(1);
                r.level_c = voice_level(2);
                advance_tick();
            end else begin
                if (w.req_type == REQ_WRITE) begin
                    store_reg(a, w.write_data);
                end else if (w.req_type == REQ_READ) begin
                    if (a >= NUM_REGS) begin
                        r.read_data = 8'hFF;
                    end else begin
                        // reading an input port latches its pins
                        if (a == REG_PORT_A && !regs[REG_ENABLE][ENABLE_PA_BIT])
                            regs[REG_PORT_A] = w.port_a_pins;
                        if (a == REG_PORT_B && !regs[REG_ENABLE][ENABLE_PB_BIT])
                            regs[REG_PORT_B] = w.port_b_pins;
                        r.read_data = regs[a] & (ay_mode ? read_bits(a) : 8'hFF);
                    end
                end
                r.level_a = voice_level(0);
                r.level_b = voice_level(1);
                r.level_c = voice_level(2);
            end
            r.port_a_drive = regs[REG_ENABLE][ENABLE_PA_BIT] ? regs[REG_PORT_A] : 8'hFF;
            r.port_b_drive = regs[REG_ENABLE][ENABLE_PB_BIT] ? regs[REG_PORT_B] : 8'hFF;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("level_a", 8'(want.level_a), 8'(got.level_a));
            compare_field("level_b", 8'(want.level_b), 8'(got.level_b));
            compare_field("level_c", 8'(want.level_c), 8'(got.level_c));
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("port_a_drive", want.port_a_drive, got.port_a_drive);
            compare_field("port_b_drive", want.port_b_drive, got.port_b_drive);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    bit          req_idle_on;
    bit          res_stall_on;
    tvsg_scoreboard sb;

    tvsg_req_if req_ch ();
    tvsg_res_if res_ch ();

    three_voice_sound_generator dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("tb_three_voice_sound_generator: errors");
        $finish;
    end

    // result side back-pressure
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            res_ch.ready <= !(res_stall_on && $urandom_range(99) < 35);
        end
    end

    // watch both channels
    always @(posedge clk) begin
        if (rst_n) begin
            if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
            if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
        end
    end

    // offer one request word, with random gaps ahead of it while req_idle_on is set
    task automatic send_word(input t_req w);
        while (req_idle_on && $urandom_range(99) < 35) begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= t_req'({$urandom, $urandom});
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic put(input logic [1:0] kind, input logic [7:0] addr,
                       input logic [7:0] data, input logic [7:0] pa = 8'h00,
                       input logic [7:0] pb = 8'hFF);
        t_req w;
        w.req_type    = kind;
        w.reg_addr    = addr;
        w.write_data  = data;
        w.port_a_pins = pa;
        w.port_b_pins = pb;
        send_word(w);
    endtask

    // stop sending and let every expected word come back; the first edge
    // makes sure the last accepted word has been noted
    task automatic wait_quiet();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_mode(input bit ay, input bit dir);
        apb_write({CFG_IS_AY, 2'b00}, {31'd0, ay});
        apb_write({CFG_FORCE_DIR, 2'b00}, {31'd0, dir});
        sb.ay_mode  = ay;
        sb.dir_rule = dir;
    endtask

    // mostly ticks and register programming with small periods
    function automatic t_req rand_word();
        t_req        w;
        int unsigned pick;
        w.req_type    = REQ_TICK;
        w.reg_addr    = 8'($urandom);
        w.write_data  = 8'($urandom);
        w.port_a_pins = 8'($urandom);
        w.port_b_pins = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 55) begin
            w.req_type = REQ_TICK;
        end else if (pick < 80) begin
            w.req_type = REQ_WRITE;
            w.reg_addr = 8'($urandom_range(NUM_REGS - 1));
            if (w.reg_addr < REG_NOISE_PER && !w.reg_addr[0] && $urandom_range(3) != 0)
                w.write_data = 8'($urandom_range(12));
            else if (w.reg_addr < REG_NOISE_PER && w.reg_addr[0] && $urandom_range(3) != 0)
                w.write_data = {4'($urandom), 4'h0};
            else if (w.reg_addr == REG_ENV_FINE && $urandom_range(3) != 0)
                w.write_data = 8'($urandom_range(3));
            else if (w.reg_addr == REG_ENV_COARSE && $urandom_range(7) != 0)
                w.write_data = 8'h00;
        end else if (pick < 93) begin
            w.req_type = REQ_READ;
            if ($urandom_range(3) != 0) w.reg_addr = 8'($urandom_range(NUM_REGS - 1));
        end else if (pick < 97) begin
            w.req_type = REQ_WRITE;
            w.reg_addr = 8'($urandom_range(255, NUM_REGS));
        end else begin
            w.req_type = REQ_NONE;
        end
        return w;
    endfunction

    // stimulus
    initial begin
        sb = new();
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        req_idle_on  = 1'b1;
        res_stall_on = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset values, masks, forced directions, ports, envelope
        put(REQ_READ, 8'(REG_ENABLE), 8'h00);
        put(REQ_WRITE, REG_TONE_A_COARSE, 8'hFF);
        put(REQ_READ, REG_TONE_A_COARSE, 8'h00);
        put(REQ_WRITE, REG_TONE_A_COARSE, 8'h00);
        put(REQ_WRITE, REG_TONE_A_FINE, 8'h01);
        put(REQ_WRITE, 8'(REG_ENABLE), 8'h40);
        put(REQ_WRITE, 8'(REG_PORT_B), 8'hA5);
        put(REQ_WRITE, 8'(REG_PORT_A), 8'h5A);
        put(REQ_READ, 8'(REG_PORT_A), 8'h00, 8'hFF, 8'h00);
        put(REQ_READ, 8'(REG_PORT_B), 8'hFF, 8'h00, 8'hFF);
        put(REQ_WRITE, 8'(VOL_BASE), 8'h1F);
        put(REQ_WRITE, 8'(VOL_BASE + 1), 8'h0F);
        put(REQ_WRITE, 8'(VOL_BASE + 2), 8'h00);
        put(REQ_WRITE, 8'(REG_ENV_SHAPE), 8'h0E);
        repeat (6) put(REQ_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        put(REQ_READ, 8'hFF, 8'h00);
        put(REQ_WRITE, 8'hFF, 8'hFF);
        put(REQ_NONE, 8'h00, 8'h00);
        put(REQ_WRITE, 8'(REG_ENV_SHAPE), 8'h0B);
        put(REQ_TICK, 8'h00, 8'h00);

        // random phases, each under its own configuration
        for (int ph = 0; ph < 4; ph++) begin
            wait_quiet();
            set_mode(PHASE_MODE[ph][1], PHASE_MODE[ph][0]);
            req_idle_on  = (ph != 1);
            res_stall_on = (ph != 1);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (ph == 0 && n == PHASE_WORDS / 2) wait_quiet();
                send_word(rand_word());
            end
        end

        wait_quiet();
        repeat (16) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_three_voice_sound_generator: clean");
        end else begin
            $display("tb_three_voice_sound_generator: errors");
        end
        $finish;
    end

endmodule
